// ===== rtl/gul_pkg.sv =====
package gul_pkg;

    typedef struct packed {
        logic [15:0]        text_index;
        logic [15:0]        word_index;
        logic signed [15:0] line_index;
        logic [15:0]        sentence_index;
        logic               end_of_paragraph;
    } t_glyph_in;

    typedef struct packed {
        logic [15:0] glyph_ordinal;
        logic [15:0] cluster_ordinal;
        logic [15:0] word_ordinal;
        logic [15:0] line_ordinal;
        logic [15:0] sentence_ordinal;
    } t_ordinals;

    typedef struct packed {
        t_ordinals   ords;
        logic [16:0] story_line;
    } t_word_entry;

    typedef struct packed {
        logic [15:0] glyph_ordinal;
        logic [15:0] cluster_ordinal;
        logic [15:0] word_ordinal;
        logic [15:0] line_ordinal;
        logic [15:0] sentence_ordinal;
        logic [16:0] story_line;
        logic [4:0]  glyph_in_word;
        logic [5:0]  word_glyph_count;
        logic        word_overflow;
        logic        last_of_run;
    } t_label_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_PUSH
    } t_state;

    localparam logic [15:0] ORD_MAX = 16'hFFFF;

endpackage

// ===== rtl/glyph_unit_labeler.sv =====
// Glyph unit labeler.
// Input channel (i_in_valid / o_in_ready, word i_in): one laid-out glyph per
// word. Output channel (o_out_valid / i_out_ready, word o_out): one label per
// buffered glyph, emitted a whole word at a time when the word ends, when the
// word buffer is full (overflow piece) or at end of paragraph.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): line offset, always
// ready; write it only while the block is idle.
// A glyph that neither starts a new word after buffered glyphs, meets a full
// buffer nor ends the paragraph is only buffered and gives no label. A flush
// streams the buffered glyphs out at one label per cycle while the receiver is
// ready, from the single read port of the word buffer, through the read and
// output registers. A flush before buffering is followed by a push state that
// writes the held glyph; no new glyph is taken until the block is idle again.
// Reset clears counters, previous indices and the fill count; the buffer
// contents are not cleared. A stalled receiver holds o_out and backs up the
// read pipeline, which in turn holds the flush and the input channel.
module glyph_unit_labeler #(
    parameter int MAX_WORD_GLYPHS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  gul_pkg::t_glyph_in    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output gul_pkg::t_label_out   o_out
);

    localparam int IDX_W  = $clog2(MAX_WORD_GLYPHS);
    localparam int FILL_W = $clog2(MAX_WORD_GLYPHS + 1);

    gul_pkg::t_state      r_state, n_state;
    logic [15:0]          r_line_offset;
    logic [15:0]          r_prev_text, r_prev_word, r_prev_line, r_prev_sentence;
    logic                 r_first;
    gul_pkg::t_ordinals   r_cnt;
    logic [FILL_W-1:0]    r_fill;
    logic                 r_split;

    gul_pkg::t_word_entry r_pend;
    logic                 r_pend_eop, r_pend_ovf;
    logic                 r_push;
    logic [FILL_W-1:0]    r_len;
    logic [FILL_W-1:0]    r_rd_idx;
    logic                 r_ovf, r_last;

    logic                 r_rd_vld;
    logic [4:0]           r_rd_gin;
    logic [5:0]           r_rd_cnt;
    logic                 r_rd_ovf, r_rd_last;
    logic                 r_out_valid;
    gul_pkg::t_label_out  r_out;

    logic                 in_acc, eop, new_word, fill_nz, buf_full, pre_flush;
    logic                 ovf_pre, split_mid;
    gul_pkg::t_ordinals   cnt_new;
    logic [15:0]          clamped;
    gul_pkg::t_word_entry entry_new;
    logic                 out_free, move, issue, last_issue;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    gul_pkg::t_word_entry wdata, rdata;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == gul_pkg::ORD_MAX) ? v : v + 16'd1;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == gul_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign eop         = i_in.end_of_paragraph;

    assign new_word  = r_first || (i_in.word_index != r_prev_word);
    assign fill_nz   = (r_fill != '0);
    assign buf_full  = (r_fill >= FILL_W'(MAX_WORD_GLYPHS));
    assign pre_flush = (fill_nz && new_word) || buf_full;
    assign ovf_pre   = (fill_nz && new_word) ? r_split : 1'b1;
    assign split_mid = (fill_nz && new_word) ? 1'b0 : (buf_full ? 1'b1 : r_split);

    always_comb begin
        if (r_first) begin
            cnt_new = '0;
        end else begin
            cnt_new.glyph_ordinal    = sat_inc(r_cnt.glyph_ordinal);
            cnt_new.cluster_ordinal  = (i_in.word_index != r_prev_word ||
                                        i_in.text_index != r_prev_text) ?
                                       sat_inc(r_cnt.cluster_ordinal) :
                                       r_cnt.cluster_ordinal;
            cnt_new.word_ordinal     = (i_in.word_index != r_prev_word) ?
                                       sat_inc(r_cnt.word_ordinal) : r_cnt.word_ordinal;
            cnt_new.line_ordinal     = (16'(i_in.line_index) != r_prev_line) ?
                                       sat_inc(r_cnt.line_ordinal) : r_cnt.line_ordinal;
            cnt_new.sentence_ordinal = (i_in.sentence_index != r_prev_sentence) ?
                                       sat_inc(r_cnt.sentence_ordinal) :
                                       r_cnt.sentence_ordinal;
        end
    end

    assign clamped              = i_in.line_index[15] ? 16'd0 : 16'(i_in.line_index);
    assign entry_new.ords       = cnt_new;
    assign entry_new.story_line = {1'b0, clamped} + {1'b0, r_line_offset};

    // read pipeline: issue -> read register -> output register
    assign out_free   = !r_out_valid || i_out_ready;
    assign move       = r_rd_vld && out_free;
    assign issue      = (r_state == gul_pkg::ST_FLUSH) && (!r_rd_vld || move);
    assign last_issue = issue && (r_rd_idx == r_len - FILL_W'(1));

    assign we    = (in_acc && !pre_flush) || (r_state == gul_pkg::ST_PUSH);
    assign waddr = (r_state == gul_pkg::ST_PUSH) ? '0 : r_fill[IDX_W-1:0];
    assign wdata = (r_state == gul_pkg::ST_PUSH) ? r_pend : entry_new;

    gul_word_buffer #(
        .DEPTH (MAX_WORD_GLYPHS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            gul_pkg::ST_IDLE: begin
                if (in_acc && (pre_flush || eop)) begin
                    n_state = gul_pkg::ST_FLUSH;
                end
            end
            gul_pkg::ST_FLUSH: begin
                if (last_issue) begin
                    n_state = r_push ? gul_pkg::ST_PUSH : gul_pkg::ST_IDLE;
                end
            end
            gul_pkg::ST_PUSH: begin
                n_state = r_pend_eop ? gul_pkg::ST_FLUSH : gul_pkg::ST_IDLE;
            end
            default: begin
                n_state = gul_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gul_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_offset   <= '0;
            r_prev_text     <= '0;
            r_prev_word     <= '0;
            r_prev_line     <= '0;
            r_prev_sentence <= '0;
            r_first         <= 1'b1;
            r_cnt           <= '0;
            r_fill          <= '0;
            r_split         <= 1'b0;
            r_rd_vld        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_offset <= i_cfg_data;
            end
            if (in_acc) begin
                r_prev_text     <= i_in.text_index;
                r_prev_word     <= i_in.word_index;
                r_prev_line     <= 16'(i_in.line_index);
                r_prev_sentence <= i_in.sentence_index;
                r_first         <= eop;
                r_cnt           <= eop ? '0 : cnt_new;
                r_split         <= eop ? 1'b0 : split_mid;
                if (pre_flush) begin
                    r_fill <= eop ? '0 : FILL_W'(1);
                end else begin
                    r_fill <= eop ? '0 : r_fill + FILL_W'(1);
                end
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (move) begin
                r_rd_vld <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            gul_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_rd_idx <= '0;
                    if (pre_flush) begin
                        // drain the old word first, hold the new glyph
                        r_len      <= r_fill;
                        r_ovf      <= ovf_pre;
                        r_last     <= !eop;
                        r_push     <= 1'b1;
                        r_pend     <= entry_new;
                        r_pend_eop <= eop;
                        r_pend_ovf <= split_mid;
                    end else begin
                        r_len  <= r_fill + FILL_W'(1);
                        r_ovf  <= split_mid;
                        r_last <= 1'b1;
                        r_push <= 1'b0;
                    end
                end
            end
            gul_pkg::ST_FLUSH: begin
                if (issue) begin
                    r_rd_idx <= r_rd_idx + FILL_W'(1);
                end
            end
            gul_pkg::ST_PUSH: begin
                r_rd_idx <= '0;
                r_len    <= FILL_W'(1);
                r_ovf    <= r_pend_ovf;
                r_last   <= 1'b1;
                r_push   <= 1'b0;
            end
            default: begin
                r_rd_idx <= '0;
            end
        endcase

        if (issue) begin
            r_rd_gin  <= 5'(r_rd_idx);
            r_rd_cnt  <= 6'(r_len);
            r_rd_ovf  <= r_ovf;
            r_rd_last <= r_last && last_issue;
        end

        if (move) begin
            r_out.glyph_ordinal    <= rdata.ords.glyph_ordinal;
            r_out.cluster_ordinal  <= rdata.ords.cluster_ordinal;
            r_out.word_ordinal     <= rdata.ords.word_ordinal;
            r_out.line_ordinal     <= rdata.ords.line_ordinal;
            r_out.sentence_ordinal <= rdata.ords.sentence_ordinal;
            r_out.story_line       <= rdata.story_line;
            r_out.glyph_in_word    <= r_rd_gin;
            r_out.word_glyph_count <= r_rd_cnt;
            r_out.word_overflow    <= r_rd_ovf;
            r_out.last_of_run      <= r_rd_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/gul_word_buffer.sv =====
module gul_word_buffer #(
    parameter int DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  gul_pkg::t_word_entry       i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output gul_pkg::t_word_entry       o_rdata
);

    gul_pkg::t_word_entry r_mem [DEPTH];
    gul_pkg::t_word_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the read word until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/glyph_unit_labeler_tb.sv =====
module glyph_unit_labeler_tb;

    localparam int WORD_CAP = 32;
    localparam int SETTLE   = 8;

    typedef struct {
        int                  new_offset;
        gul_pkg::t_glyph_in  glyph;
        int                  reps;
        bit                  pinned;
        gul_pkg::t_label_out label;
    } t_dir_step;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [15:0]         i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    gul_pkg::t_glyph_in  i_in        = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    gul_pkg::t_label_out o_out;

    // predictor state
    logic [15:0]          line_base;
    logic [15:0]          last_text, last_word, last_sentence;
    logic signed [15:0]   last_line;
    bit                   para_start;
    gul_pkg::t_ordinals   units;
    int                   fill;
    bit                   split_word;
    gul_pkg::t_word_entry held [WORD_CAP];

    gul_pkg::t_label_out labels_due [$];
    int                  errors;
    int                  idle_odds;
    bit                  pin_armed;
    gul_pkg::t_label_out pin_label;

    glyph_unit_labeler #(.MAX_WORD_GLYPHS(WORD_CAP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("glyph_unit_labeler_tb: done, errors");
        $finish;
    end

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v == gul_pkg::ORD_MAX) ? v : v + 16'd1;
    endfunction

    function automatic void emit_word(bit piece);
        gul_pkg::t_label_out lbl;
        for (int i = 0; i < fill; i++) begin
            lbl.glyph_ordinal    = held[i].ords.glyph_ordinal;
            lbl.cluster_ordinal  = held[i].ords.cluster_ordinal;
            lbl.word_ordinal     = held[i].ords.word_ordinal;
            lbl.line_ordinal     = held[i].ords.line_ordinal;
            lbl.sentence_ordinal = held[i].ords.sentence_ordinal;
            lbl.story_line       = held[i].story_line;
            lbl.glyph_in_word    = i[4:0];
            lbl.word_glyph_count = fill[5:0];
            lbl.word_overflow    = piece;
            lbl.last_of_run      = 1'b0;
            labels_due = {labels_due, lbl};
        end
        fill = 0;
    endfunction

    // Returns the number of labels this glyph releases.
    function automatic int label_glyph(gul_pkg::t_glyph_in g);
        bit          fresh_word;
        logic [16:0] clamped;
        int          run_start;
        fresh_word = para_start || (g.word_index != last_word);
        clamped    = g.line_index[15] ? 17'd0 : {1'b0, g.line_index};
        run_start  = labels_due.size();

        if (fill > 0 && fresh_word) begin
            emit_word(split_word);
            split_word = 1'b0;
        end else if (fill >= WORD_CAP) begin
            split_word = 1'b1;
            emit_word(1'b1);
        end

        if (para_start) begin
            units = '0;
        end else begin
            units.glyph_ordinal = bump(units.glyph_ordinal);
            if (g.word_index != last_word || g.text_index != last_text)
                units.cluster_ordinal = bump(units.cluster_ordinal);
            if (g.word_index != last_word)
                units.word_ordinal = bump(units.word_ordinal);
            if (g.line_index != last_line)
                units.line_ordinal = bump(units.line_ordinal);
            if (g.sentence_index != last_sentence)
                units.sentence_ordinal = bump(units.sentence_ordinal);
        end

        if (fill < WORD_CAP) begin
            held[fill].ords       = units;
            held[fill].story_line = clamped + {1'b0, line_base};
            fill++;
        end

        last_text     = g.text_index;
        last_word     = g.word_index;
        last_line     = g.line_index;
        last_sentence = g.sentence_index;
        para_start    = 1'b0;

        if (g.end_of_paragraph) begin
            emit_word(split_word);
            split_word = 1'b0;
            units      = '0;
            para_start = 1'b1;
        end

        if (labels_due.size() > run_start)
            labels_due[labels_due.size() - 1].last_of_run = 1'b1;
        return labels_due.size() - run_start;
    endfunction

    function automatic void compare_field(string name, logic [16:0] want, logic [16:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("%s: expected %h, got %h", name, want, got);
        end
    endfunction

    function automatic void check_label(gul_pkg::t_label_out got);
        gul_pkg::t_label_out want;
        if (labels_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("label with nothing expected: %h", got);
        end else begin
            want = labels_due.pop_front();
            compare_field("glyph_ordinal", 17'(want.glyph_ordinal),
                          17'(got.glyph_ordinal));
            compare_field("cluster_ordinal", 17'(want.cluster_ordinal),
                          17'(got.cluster_ordinal));
            compare_field("word_ordinal", 17'(want.word_ordinal), 17'(got.word_ordinal));
            compare_field("line_ordinal", 17'(want.line_ordinal), 17'(got.line_ordinal));
            compare_field("sentence_ordinal", 17'(want.sentence_ordinal),
                          17'(got.sentence_ordinal));
            compare_field("story_line", want.story_line, got.story_line);
            compare_field("glyph_in_word", 17'(want.glyph_in_word),
                          17'(got.glyph_in_word));
            compare_field("word_glyph_count", 17'(want.word_glyph_count),
                          17'(got.word_glyph_count));
            compare_field("word_overflow", 17'(want.word_overflow),
                          17'(got.word_overflow));
            compare_field("last_of_run", 17'(want.last_of_run), 17'(got.last_of_run));
        end
    endfunction

    initial begin
        line_base  = '0;
        last_text  = '0;
        last_word  = '0;
        last_line  = '0;
        last_sentence = '0;
        para_start = 1'b1;
        units      = '0;
        fill       = 0;
        split_word = 1'b0;
        errors     = 0;
        idle_odds  = 0;
        pin_armed  = 1'b0;
        pin_label  = '0;
    end

    always @(posedge i_clk) begin
        int released;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                line_base = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                released = label_glyph(i_in);
                // a pinned row carries its own label in place of the predicted one
                if (pin_armed) begin
                    repeat (released) void'(labels_due.pop_back());
                    labels_due = {labels_due, pin_label};
                end
            end
            if (o_out_valid && i_out_ready)
                check_label(o_out);
        end
    end

    // receiver: ready drops in bursts while idle_odds is non-zero
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_glyph(gul_pkg::t_glyph_in g, bit pin, gul_pkg::t_label_out lbl);
        int gap;
        gap = 0;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            gap = $urandom_range(1, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pin_armed  = pin;
        pin_label  = lbl;
        i_in_valid <= 1'b1;
        i_in       <= g;
        // hold the word until taken
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (labels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_paragraph(output int sent);
        gul_pkg::t_glyph_in g;
        int                 words, len;
        bit                 close;
        sent  = 0;
        words = $urandom_range(1, 6);
        close = ($urandom_range(0, 9) != 0);
        g.text_index       = 16'($urandom);
        g.word_index       = 16'($urandom);
        g.line_index       = 16'($urandom);
        g.sentence_index   = 16'($urandom);
        g.end_of_paragraph = 1'b0;
        for (int w = 0; w < words; w++) begin
            if (w > 0) begin
                case ($urandom_range(0, 7))
                    0:       g.word_index = 16'($urandom);
                    1:       ;  // same index again: words run together
                    default: g.word_index = g.word_index + 16'd1;
                endcase
                if ($urandom_range(0, 3) == 0)
                    g.sentence_index = ($urandom_range(0, 1) == 0) ? g.sentence_index + 16'd1
                                                                    : 16'($urandom);
                if ($urandom_range(0, 2) == 0)
                    g.line_index = ($urandom_range(0, 1) == 0) ? g.line_index + 16'sd1
                                                                : 16'($urandom);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 70) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
                if (k == 0 || $urandom_range(0, 2) == 0)
                    g.text_index = g.text_index + 16'($urandom_range(1, 4));
                g.end_of_paragraph = close && (w == words - 1) && (k == len - 1);
                send_glyph(g, 1'b0, '0);
                sent++;
            end
        end
    endtask

    function automatic t_dir_step mk_step(int new_offset, logic [15:0] t, logic [15:0] w,
                                          logic [15:0] l, logic [15:0] s, bit eop, int reps,
                                          bit pin, logic [16:0] story);
        t_dir_step st;
        st.new_offset             = new_offset;
        st.glyph.text_index       = t;
        st.glyph.word_index       = w;
        st.glyph.line_index       = l;
        st.glyph.sentence_index   = s;
        st.glyph.end_of_paragraph = eop;
        st.reps                   = reps;
        st.pinned                 = pin;
        st.label                  = '0;
        st.label.story_line       = story;
        st.label.word_glyph_count = 6'd1;
        st.label.last_of_run      = 1'b1;
        return st;
    endfunction

    initial begin
        t_dir_step          plan [$];
        gul_pkg::t_glyph_in g;
        int                 sent, got, next_cfg, lost;

        // lone-glyph paragraphs at the field extremes
        plan = {plan, mk_step(0, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1, 1, 1, 17'd32767)};
        plan = {plan, mk_step(-1, 0, 0, 16'h8000, 0, 1, 1, 1, 17'd0)};
        // first glyph of a paragraph starts a word even on an unchanged index
        plan = {plan, mk_step(-1, 0, 0, 16'hFFFF, 0, 0, 1, 0, 0)};
        plan = {plan, mk_step(-1, 1, 0, 16'hFFFF, 0, 0, 1, 0, 0)};
        plan = {plan, mk_step(-1, 1, 0, 0, 1, 0, 1, 0, 0)};
        plan = {plan, mk_step(-1, 2, 1, 0, 1, 0, 1, 0, 0)};
        plan = {plan, mk_step(-1, 2, 1, 0, 1, 1, 1, 0, 0)};
        // word longer than the buffer: split into flagged pieces
        plan = {plan, mk_step(-1, 5, 7, 3, 2, 0, 33, 0, 0)};
        plan = {plan, mk_step(-1, 6, 7, 3, 2, 0, 1, 0, 0)};
        plan = {plan, mk_step(-1, 7, 8, 3, 2, 1, 1, 0, 0)};
        // word that fills the buffer exactly, then ends
        plan = {plan, mk_step(-1, 9, 9, 4, 3, 0, 32, 0, 0)};
        plan = {plan, mk_step(-1, 10, 10, 4, 3, 1, 1, 0, 0)};
        plan = {plan, mk_step(65535, 0, 0, 16'h7FFF, 0, 1, 1, 1, 17'd98302)};
        plan = {plan, mk_step(-1, 0, 0, 16'h8000, 0, 1, 1, 1, 17'd65535)};
        plan = {plan, mk_step(-1, 16'h1234, 16'h5678, 16'h0001, 16'h9ABC, 1, 1, 1,
                              17'd65536)};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sent      = 0;
        idle_odds = 4;
        foreach (plan[i]) begin
            if (plan[i].new_offset >= 0) begin
                drain();
                write_offset(plan[i].new_offset[15:0]);
            end
            repeat (plan[i].reps) send_glyph(plan[i].glyph, plan[i].pinned, plan[i].label);
            sent += plan[i].reps;
        end
        drain();

        next_cfg = 0;
        while (sent < 340) begin
            if (sent >= next_cfg) begin
                drain();
                case ($urandom_range(0, 2))
                    0:       write_offset(16'h0000);
                    1:       write_offset(16'hFFFF);
                    default: write_offset(16'($urandom));
                endcase
                next_cfg = sent + 120;
            end
            case ($urandom_range(0, 3))
                0:       idle_odds = 0;
                1:       idle_odds = 3;
                2:       idle_odds = 6;
                default: idle_odds = 10;
            endcase
            if ($urandom_range(0, 7) == 0) begin
                g.text_index       = 16'($urandom);
                g.word_index       = 16'($urandom);
                g.line_index       = 16'($urandom);
                g.sentence_index   = 16'($urandom);
                g.end_of_paragraph = ($urandom_range(0, 3) == 0);
                send_glyph(g, 1'b0, '0);
                sent++;
            end else begin
                send_paragraph(got);
                sent += got;
            end
            if ($urandom_range(0, 4) == 0)
                drain();
        end

        idle_odds = 0;
        while (sent < 400) begin
            send_paragraph(got);
            sent += got;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (int c = 0; c < 50000 && labels_due.size() != 0; c++) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        lost = labels_due.size();
        if (lost != 0)
            $display("%0d expected labels never arrived", lost);
        if (errors == 0 && lost == 0)
            $display("glyph_unit_labeler_tb: done, clean");
        else
            $display("glyph_unit_labeler_tb: done, errors");
        $finish;
    end

endmodule

// ===== glyph_unit_labeler.f =====
rtl/gul_pkg.sv
rtl/gul_word_buffer.sv
rtl/glyph_unit_labeler.sv
dv/glyph_unit_labeler_tb.sv
